[rtl/bbia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbia_pkg
// Shared types and constants for the bitmap block and inode allocator.
// ----------------------------------------------------------------------------
package bbia_pkg;

  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 13;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 2;
  localparam int WORD_W    = 64;
  localparam int BIT_W     = 6;
  localparam int CNT_MAX   = (1 << COUNT_W) - 1;

  localparam logic [CFG_IDX_W-1:0] CFG_BLK_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INO_TOTAL  = 2'd2;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;
  localparam logic POOL_DATA    = 1'b0;
  localparam logic POOL_INODE   = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_REL,
    S_RELWR,
    S_DONE
  } state_e;

endpackage

[rtl/bbia_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbia channel interfaces
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface bbia_req_if import bbia_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic              pool;
  logic [DATA_W-1:0] index;

  modport source (output valid, mode, pool, index, input ready);
  modport sink   (input valid, mode, pool, index, output ready);
endinterface

interface bbia_rsp_if import bbia_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [DATA_W-1:0]   value;

  modport source (output valid, status, value, input ready);
  modport sink   (input valid, status, value, output ready);
endinterface

interface bbia_cfg_if import bbia_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[rtl/bitmap_block_inode_allocator_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_inode_allocator_unit
// First-fit allocator over two free maps (data blocks, inodes) held in one
// synchronous map memory, 64-bit words, read-modify-write.
// ----------------------------------------------------------------------------
// channel  dir  word
// req_i    in   mode, pool, index
// rsp_o    out  status, value
// cfg_i    in   index (0 block base, 1 data count, 2 inode total), data
//
// Allocate: one map word tested per cycle until a free bit is found or the pool
// limit is passed. Release: a map read then a write, no access when out of range.
// After reset a clearing pass fills the map memory; no request is taken meanwhile.
// A request is taken while a response still waits on rsp_o; a stalled
// response holds the next finished word back in a result register.
// ----------------------------------------------------------------------------
module bitmap_block_inode_allocator_unit import bbia_pkg::*; #(
  parameter int MAP_BITS = 4096
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  bbia_req_if.sink   req_i,
  bbia_rsp_if.source rsp_o,
  bbia_cfg_if.sink   cfg_i
);

  localparam int MAP_WORDS = (MAP_BITS + WORD_W - 1) / WORD_W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int WCW       = $clog2(MAP_WORDS + 1);
  localparam int MEM_DEPTH = 2 << AW;
  localparam int PW        = AW + BIT_W;
  localparam int LIM_MAX   = (MAP_BITS < CNT_MAX) ? MAP_BITS : CNT_MAX;
  localparam int LW        = $clog2(LIM_MAX + 1);
  localparam logic [AW:0] ROOT_ADDR = {1'b1, {AW{1'b0}}};

  state_e state_q, state_d;

  logic [DATA_W-1:0]  blk_base_q;
  logic [COUNT_W-1:0] data_count_q, ino_total_q;

  logic [AW:0]         clr_ptr_q, clr_ptr_d;
  logic [WCW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]       ev_ptr_q, ev_ptr_d;
  logic                ev_vld_q, ev_vld_d;
  logic                req_mode_q, req_pool_q;
  logic [DATA_W-1:0]   req_rel_q;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [DATA_W-1:0]   res_value_q, res_value_d;
  logic                out_vld_q, out_vld_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [DATA_W-1:0]   out_value_q;

  logic [WORD_W-1:0] mem_q [MEM_DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we, mem_re;
  logic [AW:0]       mem_waddr, mem_raddr;
  logic [WORD_W-1:0] mem_wdata;

  logic              accept, out_free, load_out;
  logic [COUNT_W-1:0] cnt;
  logic [LW-1:0]     lim;
  logic [WORD_W-1:0] free_bits;
  logic              has_free;
  logic [BIT_W-1:0]  fz_idx;
  logic [PW-1:0]     pos;
  logic [DATA_W-1:0] next_base;
  logic [AW-1:0]     rel_word;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !out_vld_q || rsp_o.ready;
  assign cnt      = req_pool_q ? ino_total_q : data_count_q;
  assign lim      = (32'(cnt) > 32'(MAP_BITS)) ? LW'(LIM_MAX) : LW'(cnt);
  assign rel_word = req_rel_q[PW-1:BIT_W];

  // first free bit of the word under test
  assign free_bits = ~rdata_q;
  assign has_free  = |free_bits;
  always_comb begin
    fz_idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        fz_idx = BIT_W'(i);
      end
    end
  end
  assign pos       = {ev_ptr_q, fz_idx};
  assign next_base = (32'(ev_ptr_q) + 32'd1) << BIT_W;

  // register writes
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_base_q   <= '0;
      data_count_q <= COUNT_W'(4096);
      ino_total_q  <= COUNT_W'(4096);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_BLK_BASE:   blk_base_q   <= cfg_i.data;
        CFG_DATA_COUNT: data_count_q <= cfg_i.data[COUNT_W-1:0];
        CFG_INO_TOTAL:  ino_total_q  <= cfg_i.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // map memory
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  always_comb begin
    state_d      = state_q;
    clr_ptr_d    = clr_ptr_q;
    rd_ptr_d     = rd_ptr_q;
    ev_ptr_d     = ev_ptr_q;
    ev_vld_d     = 1'b0;
    res_status_d = res_status_q;
    res_value_d  = res_value_q;
    load_out     = 1'b0;
    req_i.ready  = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = {req_pool_q, ev_ptr_q};
    mem_raddr    = {req_pool_q, rd_ptr_q[AW-1:0]};
    mem_wdata    = rdata_q | (64'd1 << fz_idx);
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr_q;
        mem_wdata = (clr_ptr_q == ROOT_ADDR) ? 64'd1 : '0;
        clr_ptr_d = clr_ptr_q + 1'b1;
        if (&clr_ptr_q) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        req_i.ready = 1'b1;
        rd_ptr_d    = '0;
        if (accept) begin
          state_d = (req_i.mode == MODE_RELEASE) ? S_REL : S_SCAN;
        end
      end
      S_SCAN: begin
        ev_ptr_d = rd_ptr_q[AW-1:0];
        if (rd_ptr_q < WCW'(MAP_WORDS)) begin
          mem_re   = 1'b1;
          rd_ptr_d = rd_ptr_q + 1'b1;
          ev_vld_d = 1'b1;
        end
        if (ev_vld_q) begin
          if (has_free) begin
            state_d     = S_DONE;
            res_value_d = '0;
            if (32'(pos) < 32'(lim)) begin
              mem_we       = 1'b1;
              res_status_d = STAT_OK;
              res_value_d  = (req_pool_q == POOL_INODE) ? 32'(pos)
                                                        : blk_base_q + 32'(pos);
            end else begin
              res_status_d = STAT_FULL;
            end
          end else if (next_base >= 32'(lim)) begin
            state_d      = S_DONE;
            res_status_d = STAT_FULL;
            res_value_d  = '0;
          end
        end
      end
      S_REL: begin
        res_value_d = '0;
        if (req_rel_q >= 32'(lim)) begin
          res_status_d = STAT_RANGE;
          state_d      = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = {req_pool_q, rel_word};
          state_d   = S_RELWR;
        end
      end
      S_RELWR: begin
        mem_we       = 1'b1;
        mem_waddr    = {req_pool_q, rel_word};
        mem_wdata    = rdata_q & ~(64'd1 << req_rel_q[BIT_W-1:0]);
        res_status_d = STAT_OK;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_vld_d = load_out ? 1'b1 : (rsp_o.ready ? 1'b0 : out_vld_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_ptr_q <= '0;
      rd_ptr_q  <= '0;
      ev_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_ptr_q <= clr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      ev_vld_q  <= ev_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_ptr_q     <= ev_ptr_d;
    res_status_q <= res_status_d;
    res_value_q  <= res_value_d;
    if (accept) begin
      req_mode_q <= req_i.mode;
      req_pool_q <= req_i.pool;
      req_rel_q  <= (req_i.pool == POOL_INODE) ? req_i.index : req_i.index - blk_base_q;
    end
    if (load_out) begin
      out_status_q <= res_status_q;
      out_value_q  <= res_value_q;
    end
  end

  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.value  = out_value_q;

  // checks
  a_err_value_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status != STAT_OK) |-> rsp_o.value == '0)
    else $error("error response carries a non-zero value");

  a_scan_write_in_map : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && (state_q == S_SCAN) |-> (32'(ev_ptr_q) < MAP_WORDS) && (req_mode_q == MODE_ALLOC))
    else $error("allocation write outside the map");

  a_load_from_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_DONE))
    else $error("response raised outside the done state");

  a_relwr_after_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RELWR) |-> $past(state_q == S_REL) && (req_mode_q == MODE_RELEASE))
    else $error("release write without preceding read");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap block and inode allocator. A bench-side
// copy of both free maps and the three registers predicts status and value
// for each request word; every response word is checked against the oldest
// prediction. Directed cases, random traffic over several register settings,
// back-pressure and drain pauses, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import bbia_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int MAP_ENTRIES = 4096;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASE_WORDS = 200;

  typedef struct packed {
    status_e           status;
    logic [DATA_W-1:0] value;
  } alloc_result_t;

  logic clk_i;
  logic rst_ni;

  bbia_req_if req_if ();
  bbia_rsp_if rsp_if ();
  bbia_cfg_if cfg_if ();

  bitmap_block_inode_allocator_unit #(
    .MAP_BITS(MAP_ENTRIES)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  // bench copy of the block state
  logic [MAP_ENTRIES-1:0] data_used;
  logic [MAP_ENTRIES-1:0] inode_used;
  logic [DATA_W-1:0]      blk_base_q;
  logic [COUNT_W-1:0]     data_count_q;
  logic [COUNT_W-1:0]     ino_total_q;

  alloc_result_t pending_results[$];
  int            mismatch_count;
  int            quiet_cycles;
  int            send_idle_pct;
  int            rcv_idle_pct;
  int            rsp_hold_left;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic int unsigned pool_limit(input logic pool);
    int unsigned lim;
    lim = (pool == POOL_INODE) ? ino_total_q : data_count_q;
    if (lim > MAP_ENTRIES) lim = MAP_ENTRIES;
    return lim;
  endfunction

  function automatic alloc_result_t apply_map_request(input logic mode, input logic pool,
                                                      input logic [DATA_W-1:0] idx);
    alloc_result_t r;
    int unsigned   lim;
    int            found;
    logic [DATA_W-1:0] rel;
    r.status = STAT_OK;
    r.value  = '0;
    lim      = pool_limit(pool);
    if (mode == MODE_ALLOC) begin
      found = -1;
      for (int i = 0; i < int'(lim) && found < 0; i++) begin
        if (pool == POOL_INODE ? !inode_used[i] : !data_used[i]) found = i;
      end
      if (found < 0) begin
        r.status = STAT_FULL;
      end else if (pool == POOL_INODE) begin
        inode_used[found] = 1'b1;
        r.value = DATA_W'(found);
      end else begin
        data_used[found] = 1'b1;
        r.value = blk_base_q + DATA_W'(found);
      end
    end else begin
      rel = (pool == POOL_INODE) ? idx : idx - blk_base_q;
      if (rel >= lim) begin
        r.status = STAT_RANGE;
      end else if (pool == POOL_INODE) begin
        inode_used[rel[11:0]] = 1'b0;
      end else begin
        data_used[rel[11:0]] = 1'b0;
      end
    end
    return r;
  endfunction

  // prediction, checking and watchdog
  always @(posedge clk_i) begin : monitor
    alloc_result_t want;
    logic          moved;
    if (!rst_ni) begin
      data_used     = '0;
      inode_used    = '0;
      inode_used[0] = 1'b1;
      blk_base_q    = '0;
      data_count_q  = COUNT_W'(MAP_ENTRIES);
      ino_total_q   = COUNT_W'(MAP_ENTRIES);
      quiet_cycles  = 0;
    end else begin
      moved = 1'b0;
      if (rsp_if.valid && rsp_if.ready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $error("response word with nothing expected: status %0d value %0h",
                 rsp_if.status, rsp_if.value);
          mismatch_count++;
        end else begin
          want = pending_results.pop_front();
          if (rsp_if.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
            mismatch_count++;
          end
          if (rsp_if.value !== want.value) begin
            $error("value: expected %0h, actual %0h", want.value, rsp_if.value);
            mismatch_count++;
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        moved = 1'b1;
        pending_results.push_back(apply_map_request(req_if.mode, req_if.pool, req_if.index));
      end
      if (cfg_if.valid && cfg_if.ready) begin
        moved = 1'b1;
        case (cfg_if.index)
          CFG_BLK_BASE:   blk_base_q   = cfg_if.data;
          CFG_DATA_COUNT: data_count_q = cfg_if.data[COUNT_W-1:0];
          CFG_INO_TOTAL:  ino_total_q  = cfg_if.data[COUNT_W-1:0];
          default: ;
        endcase
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // response side: random stalls plus long hold-offs on request
  always @(negedge clk_i) begin
    if (rsp_hold_left > 0) begin
      rsp_hold_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  task automatic set_idle(input int send_pct, input int rcv_pct);
    send_idle_pct = send_pct;
    rcv_idle_pct  = rcv_pct;
  endtask

  // leaves valid high on return so back-to-back words need no re-raise
  task automatic send_word(input logic mode, input logic pool, input logic [DATA_W-1:0] idx);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.mode  <= mode;
    req_if.pool  <= pool;
    req_if.index <= idx;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [DATA_W-1:0] start, input int dcount, input int icount);
    wait_drained();
    cfg_write(CFG_BLK_BASE, start);
    cfg_write(CFG_DATA_COUNT, DATA_W'(dcount));
    cfg_write(CFG_INO_TOTAL, DATA_W'(icount));
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_random_word();
    logic              mode;
    logic              pool;
    logic [DATA_W-1:0] rel;
    logic [DATA_W-1:0] idx;
    int unsigned       lim;
    mode = ($urandom_range(0, 99) < 55) ? MODE_ALLOC : MODE_RELEASE;
    pool = 1'($urandom_range(0, 1));
    lim  = pool_limit(pool);
    idx  = $urandom;
    if (mode == MODE_RELEASE) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: rel = $urandom_range(0, lim + 1);
        6:                rel = $urandom;
        7:                rel = lim - 1 + $urandom_range(0, 2);
        8:                rel = -$urandom_range(1, 8);
        default:          rel = '0;
      endcase
      idx = (pool == POOL_INODE) ? rel : blk_base_q + rel;
    end
    send_word(mode, pool, idx);
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] start, input int dcount, input int icount);
    set_config(start, dcount, icount);
    repeat (PHASE_WORDS) send_random_word();
  endtask

  task automatic test_directed();
    send_word(MODE_ALLOC,   POOL_DATA,  32'h0000_0000);
    send_word(MODE_ALLOC,   POOL_INODE, 32'hFFFF_FFFF);
    send_word(MODE_RELEASE, POOL_INODE, 32'h0000_0000); // root inode
    send_word(MODE_ALLOC,   POOL_INODE, 32'h0000_0000);
    send_word(MODE_RELEASE, POOL_DATA,  32'hFFFF_FFFF);
    send_word(MODE_RELEASE, POOL_DATA,  32'h0000_0FFF); // already free
    send_word(MODE_RELEASE, POOL_INODE, 32'h0000_1000);
    send_word(MODE_RELEASE, POOL_INODE, 32'hFFFF_FFFF);
    send_word(MODE_RELEASE, POOL_DATA,  32'h0000_0000);
    // counts above the map size, block base at its top
    set_config(32'hFFFF_EFFF, 8191, 4097);
    send_word(MODE_ALLOC,   POOL_DATA,  32'h8000_0000);
    send_word(MODE_RELEASE, POOL_DATA,  32'h0000_0005); // below block base
    send_word(MODE_RELEASE, POOL_DATA,  32'hFFFF_FFFE);
    send_word(MODE_RELEASE, POOL_DATA,  32'hFFFF_FFFF);
    send_word(MODE_ALLOC,   POOL_INODE, 32'h0000_0000);
    // empty pools
    set_config(32'h0001_0000, 0, 0);
    send_word(MODE_ALLOC,   POOL_DATA,  32'h0000_0000);
    send_word(MODE_ALLOC,   POOL_INODE, 32'h0000_0000);
    send_word(MODE_RELEASE, POOL_DATA,  32'h0001_0000);
    send_word(MODE_RELEASE, POOL_INODE, 32'h0000_0000);
    // tiny pools run full
    set_config(32'h8000_0000, 2, 3);
    send_word(MODE_ALLOC,   POOL_DATA,  32'h0000_0000);
    send_word(MODE_ALLOC,   POOL_DATA,  32'h0000_0000);
    send_word(MODE_ALLOC,   POOL_INODE, 32'h0000_0000);
    send_word(MODE_RELEASE, POOL_INODE, 32'h0000_0002);
    send_word(MODE_ALLOC,   POOL_INODE, 32'h0000_0000);
  endtask

  task automatic test_random_traffic();
    set_idle(10, 50);
    run_phase(32'h0000_0000, 4096, 4096);
    run_phase(32'hFFFF_EFFF, 8191, 4097);
    run_phase($urandom_range(0, 32'hFFFF_EFFF), 0, 1);
    set_idle(50, 10);
    run_phase($urandom_range(0, 32'hFFFF_EFFF), 64, 65);
    run_phase($urandom_range(0, 32'hFFFF_EFFF), $urandom_range(1, 40), $urandom_range(1, 40));
    run_phase($urandom_range(0, 32'hFFFF_EFFF), 4095, 128);
    set_idle(0, 0);
    run_phase($urandom_range(0, 32'hFFFF_EFFF), $urandom_range(1, 200), 0);
    run_phase($urandom_range(0, 32'hFFFF_EFFF), 130, $urandom_range(1, 300));
    run_phase(32'h0000_0000, 1, 4096);
  endtask

  task automatic test_backpressure();
    set_config($urandom_range(0, 32'hFFFF_EFFF), 48, 48);
    set_idle(0, 0);
    rsp_hold_left = 400;
    repeat (24) send_random_word();
    wait_drained();
  endtask

  task automatic test_drain_pause();
    set_idle(10, 10);
    repeat (10) send_random_word();
    wait_drained();
    repeat (10) send_random_word();
    wait_drained();
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.mode    = MODE_ALLOC;
    req_if.pool    = POOL_DATA;
    req_if.index   = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = CFG_BLK_BASE;
    cfg_if.data    = '0;
    rsp_if.ready   = 1'b0;
    mismatch_count = 0;
    rsp_hold_left  = 0;
    set_idle(10, 50);
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_random_traffic();
    test_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/bbia_pkg.sv
rtl/bbia_if.sv
rtl/bitmap_block_inode_allocator_unit.sv
verif/tb_top.sv
